/* src/one_wire_bus_master_assert.svh */
// Assertion macros shared by the 1-Wire bus master modules.
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define OWBM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define OWBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/owbm_pkg.sv */
// Package: request/result types, configuration type and command codes.
`default_nettype none

package owbm_pkg;

    localparam int unsigned TickW = 10;

    // Request kinds
    localparam logic [2:0] K_TICK  = 3'd0;
    localparam logic [2:0] K_RESET = 3'd1;
    localparam logic [2:0] K_WBYTE = 3'd2;
    localparam logic [2:0] K_RBYTE = 3'd3;
    localparam logic [2:0] K_WBIT  = 3'd4;
    localparam logic [2:0] K_RBIT  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PRES  = 2'd1;
    localparam logic [1:0] ST_BUS_LOW  = 2'd2;

    // Timing register indexes on the write port
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_AFTER_RESET   = 3'd2;
    localparam logic [2:0] REG_HOLD_LOW      = 3'd3;
    localparam logic [2:0] REG_WRITE_SLOT    = 3'd4;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [2:0] REG_READ_RECOVERY = 3'd6;
    localparam int unsigned REG_COUNT        = 7;

    typedef struct packed {
        logic [2:0] kind;
        logic       line_level;
        logic [7:0] data_value;
    } t_in_req;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
        logic       rejected;
    } t_out_res;

    typedef struct packed {
        logic [TickW-1:0] reset_low_ticks;
        logic [TickW-1:0] presence_wait_ticks;
        logic [TickW-1:0] after_reset_ticks;
        logic [TickW-1:0] hold_low_ticks;
        logic [TickW-1:0] write_slot_ticks;
        logic [TickW-1:0] read_sample_ticks;
        logic [TickW-1:0] read_recovery_ticks;
    } t_cfg;

    // A zero duration in a register that starts at one counts as one tick
    function automatic logic [TickW-1:0] min_one(input logic [TickW-1:0] v);
        min_one = (v == '0) ? TickW'(1) : v;
    endfunction

endpackage

`default_nettype wire

/* src/owbm_cfg_regs.sv */
// Timing configuration registers written through the plain write port.
`default_nettype none

module owbm_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [2:0]                  i_cfg_index,
    input  wire logic [owbm_pkg::TickW-1:0]  i_cfg_data,
    output owbm_pkg::t_cfg                   o_cfg
);

    owbm_pkg::t_cfg r_cfg;
    owbm_pkg::t_cfg n_cfg;

    // Decode the write; indexes past the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                owbm_pkg::REG_RESET_LOW:     n_cfg.reset_low_ticks     = i_cfg_data;
                owbm_pkg::REG_PRESENCE_WAIT: n_cfg.presence_wait_ticks = i_cfg_data;
                owbm_pkg::REG_AFTER_RESET:   n_cfg.after_reset_ticks   = i_cfg_data;
                owbm_pkg::REG_HOLD_LOW:      n_cfg.hold_low_ticks      = i_cfg_data;
                owbm_pkg::REG_WRITE_SLOT:    n_cfg.write_slot_ticks    = i_cfg_data;
                owbm_pkg::REG_READ_SAMPLE:   n_cfg.read_sample_ticks   = i_cfg_data;
                owbm_pkg::REG_READ_RECOVERY: n_cfg.read_recovery_ticks = i_cfg_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= 10'd480;
            r_cfg.presence_wait_ticks <= 10'd70;
            r_cfg.after_reset_ticks   <= 10'd410;
            r_cfg.hold_low_ticks      <= 10'd1;
            r_cfg.write_slot_ticks    <= 10'd59;
            r_cfg.read_sample_ticks   <= 10'd15;
            r_cfg.read_recovery_ticks <= 10'd45;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/owbm_seq.sv */
// Bus sequencer: slot timing state machine stepped once per accepted request.
`default_nettype none

`include "one_wire_bus_master_assert.svh"

module owbm_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire owbm_pkg::t_in_req  i_req,
    input  wire owbm_pkg::t_cfg     i_cfg,
    output owbm_pkg::t_out_res      o_res
);

    // Phase codes
    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_RST_LOW      = 3'd1;
    localparam logic [2:0] PH_RST_WAIT     = 3'd2;
    localparam logic [2:0] PH_RST_AFTER    = 3'd3;
    localparam logic [2:0] PH_SLOT_LOW     = 3'd4;
    localparam logic [2:0] PH_SLOT_WRITE   = 3'd5;
    localparam logic [2:0] PH_READ_WAIT    = 3'd6;
    localparam logic [2:0] PH_READ_RECOVER = 3'd7;

    logic [2:0]                  r_phase, n_phase;
    logic [2:0]                  r_cmd, n_cmd;
    logic [owbm_pkg::TickW-1:0]  r_tick, n_tick;
    logic [2:0]                  r_bit, n_bit;
    logic [7:0]                  r_shift, n_shift;
    logic [1:0]                  r_status, n_status;
    logic                        r_drive, n_drive;
    logic                        fin;
    logic                        rej;
    logic                        more_bits;
    logic                        is_write;

    assign more_bits = ((r_cmd == owbm_pkg::K_WBYTE) || (r_cmd == owbm_pkg::K_RBYTE))
                       && (r_bit != 3'd7);
    assign is_write  = (r_cmd == owbm_pkg::K_WBYTE) || (r_cmd == owbm_pkg::K_WBIT);

    // Next state for one request
    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_status = r_status;
        n_drive  = r_drive;
        fin      = 1'b0;
        rej      = 1'b0;

        if (i_req.kind == owbm_pkg::K_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (r_tick > owbm_pkg::TickW'(1)) begin
                    n_tick = r_tick - owbm_pkg::TickW'(1);
                end else begin
                    // End of the current phase
                    case (r_phase)
                        PH_RST_LOW: begin
                            n_drive = 1'b0;
                            n_phase = PH_RST_WAIT;
                            n_tick  = owbm_pkg::min_one(i_cfg.presence_wait_ticks);
                        end
                        PH_RST_WAIT: begin
                            n_status = i_req.line_level ? owbm_pkg::ST_NO_PRES
                                                        : owbm_pkg::ST_OK;
                            if (i_cfg.after_reset_ticks == '0) begin
                                fin     = 1'b1;
                                n_phase = PH_IDLE;
                                n_drive = 1'b0;
                            end else begin
                                n_phase = PH_RST_AFTER;
                                n_tick  = i_cfg.after_reset_ticks;
                            end
                        end
                        PH_SLOT_LOW: begin
                            if (is_write) begin
                                if (r_shift[r_bit]) begin
                                    n_drive = 1'b0;
                                end
                                n_phase = PH_SLOT_WRITE;
                                n_tick  = owbm_pkg::min_one(i_cfg.write_slot_ticks);
                            end else begin
                                n_drive = 1'b0;
                                n_phase = PH_READ_WAIT;
                                n_tick  = owbm_pkg::min_one(i_cfg.read_sample_ticks);
                            end
                        end
                        PH_READ_WAIT: begin
                            if (i_req.line_level) begin
                                n_shift[r_bit] = 1'b1;
                            end
                            if (i_cfg.read_recovery_ticks != '0) begin
                                n_phase = PH_READ_RECOVER;
                                n_tick  = i_cfg.read_recovery_ticks;
                            end else if (more_bits) begin
                                n_bit   = r_bit + 3'd1;
                                n_drive = 1'b1;
                                n_phase = PH_SLOT_LOW;
                                n_tick  = owbm_pkg::min_one(i_cfg.hold_low_ticks);
                            end else begin
                                fin     = 1'b1;
                                n_phase = PH_IDLE;
                                n_drive = 1'b0;
                            end
                        end
                        PH_SLOT_WRITE, PH_READ_RECOVER: begin
                            if (more_bits) begin
                                n_bit   = r_bit + 3'd1;
                                n_drive = 1'b1;
                                n_phase = PH_SLOT_LOW;
                                n_tick  = owbm_pkg::min_one(i_cfg.hold_low_ticks);
                            end else begin
                                fin     = 1'b1;
                                n_phase = PH_IDLE;
                                n_drive = 1'b0;
                            end
                        end
                        default: begin
                            // After-reset wait ends the command
                            fin     = 1'b1;
                            n_phase = PH_IDLE;
                            n_drive = 1'b0;
                        end
                    endcase
                end
            end
        end else if (i_req.kind <= owbm_pkg::K_RBIT) begin
            if (r_phase != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                // Start a new command
                n_cmd    = i_req.kind;
                n_status = owbm_pkg::ST_OK;
                n_bit    = 3'd0;
                n_shift  = 8'd0;
                if (i_req.kind == owbm_pkg::K_RESET) begin
                    if (!i_req.line_level) begin
                        n_status = owbm_pkg::ST_BUS_LOW;
                        fin      = 1'b1;
                        n_phase  = PH_IDLE;
                        n_drive  = 1'b0;
                    end else begin
                        n_drive = 1'b1;
                        n_phase = PH_RST_LOW;
                        n_tick  = owbm_pkg::min_one(i_cfg.reset_low_ticks);
                    end
                end else begin
                    if (i_req.kind == owbm_pkg::K_WBYTE) begin
                        n_shift = i_req.data_value;
                    end else if (i_req.kind == owbm_pkg::K_WBIT) begin
                        n_shift = {7'd0, i_req.data_value[0]};
                    end
                    n_drive = 1'b1;
                    n_phase = PH_SLOT_LOW;
                    n_tick  = owbm_pkg::min_one(i_cfg.hold_low_ticks);
                end
            end
        end
    end

    // Result fields for this request
    always_comb begin
        o_res.drive_low = n_drive;
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = fin;
        o_res.rejected  = rej;
        o_res.status    = (fin && (n_cmd == owbm_pkg::K_RESET)) ? n_status : 2'd0;
        if (fin && (n_cmd == owbm_pkg::K_RBYTE)) begin
            o_res.read_data = n_shift;
        end else if (fin && (n_cmd == owbm_pkg::K_RBIT)) begin
            o_res.read_data = {7'd0, n_shift[0]};
        end else begin
            o_res.read_data = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cmd    <= 3'd0;
            r_tick   <= '0;
            r_bit    <= 3'd0;
            r_shift  <= 8'd0;
            r_status <= owbm_pkg::ST_OK;
            r_drive  <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_tick   <= n_tick;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_status <= n_status;
            r_drive  <= n_drive;
        end
    end

    // An idle sequencer never pulls the line
    `OWBM_ASSERT_IMPLY(a_idle_released, i_clk, i_rst_n, r_phase == PH_IDLE, !r_drive, "drive low while idle")
    // A rejected command leaves the running command in place
    `OWBM_ASSERT_NEXT(a_reject_keeps, i_clk, i_rst_n, i_accept && rej, (r_phase != PH_IDLE) && (r_cmd == $past(r_cmd)), "rejected command disturbed state")
    // A finished command leaves the sequencer idle
    `OWBM_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, i_accept && fin, r_phase == PH_IDLE, "not idle after done")

endmodule

`default_nettype wire

/* src/owbm_out_buf.sv */
// Result register with a skid stage so requests keep flowing while a result waits.
`default_nettype none

`include "one_wire_bus_master_assert.svh"

module owbm_out_buf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire owbm_pkg::t_out_res  i_res,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output owbm_pkg::t_out_res       o_out_res
);

    logic               r_out_valid;
    logic               r_skid_valid;
    owbm_pkg::t_out_res r_out;
    owbm_pkg::t_out_res r_skid;
    logic               accept;
    logic               out_free;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Control: the skid entry drains first into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= i_res;
            end
        end else if (accept) begin
            r_skid <= i_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    `OWBM_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with empty result register")
    `OWBM_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, accept && r_out_valid && i_out_stall, r_skid_valid, "request lost under stall")
    `OWBM_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall, !r_skid_valid && r_out_valid, "skid did not drain")

endmodule

`default_nettype wire

/* src/one_wire_bus_master.sv */
// 1-Wire bus master: one request a cycle while o_in_stall is low; each result is registered.
// Throughput: one request per cycle while o_in_stall is low; the sequencer state advances on every accept.
// o_in_stall rises only while a second result sits in the skid stage behind a stalled output.
// Reset (i_rst_n low, synchronous): sequencer idle with line released, no results pending,
// timing registers at their default values.
`default_nettype none

module one_wire_bus_master (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire owbm_pkg::t_in_req           i_in_req,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output owbm_pkg::t_out_res               o_out_res,
    input  wire logic                        i_cfg_we,
    input  wire logic [2:0]                  i_cfg_index,
    input  wire logic [owbm_pkg::TickW-1:0]  i_cfg_data
);

    owbm_pkg::t_cfg     cfg;
    owbm_pkg::t_out_res res;
    logic               accept;

    assign accept = i_in_valid && !o_in_stall;

    owbm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    owbm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    owbm_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_res       (res),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire
